// ----- rtl/core/swmc_pkg.sv -----
// Package for the side wall mode classifier: word types, register indexes,
// mode codes and the widths derived from the window length and sample width.
// Depends on nothing; every file of the block refers to it by scoped names.
package swmc_pkg;

  // Moving window length in words, and the number of significant sample bits.
  localparam int WINDOW      = 8;
  localparam int SAMPLE_BITS = 12;

  // Fixed widths of the port fields.
  localparam int FIELD_BITS = 12;
  localparam int REG_BITS   = 12;
  localparam int THR_BITS   = 13;

  // Samples are taken in their low SAMPLE_BITS bits, never wider than the field.
  localparam int SAMPLE_W   = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
  localparam int WIN_LOG    = $clog2(WINDOW);
  localparam int POS_BITS   = (WINDOW > 1) ? WIN_LOG : 1;
  localparam int SUM_BITS   = SAMPLE_W + WIN_LOG;
  localparam int LIMIT_BITS = REG_BITS + WIN_LOG;
  localparam int CMP_BITS   = (SUM_BITS > LIMIT_BITS) ? SUM_BITS : LIMIT_BITS;
  localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(WINDOW - 1);
  localparam logic [SUM_BITS-1:0] SUM_MAX  =
    SUM_BITS'(WINDOW * ((1 << SAMPLE_W) - 1));

  // Configuration register indexes.
  localparam int IDX_BITS = 2;
  localparam logic [IDX_BITS-1:0] REG_CHANGE_THRESHOLD = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_BASE_THRESHOLD   = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_THRESHOLD_EXTRA  = 2'd2;

  // Wall mode codes.
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;
  localparam logic [1:0] MODE_BOTH  = 2'd3;

  typedef struct packed {
    logic [FIELD_BITS-1:0] left_sample;
    logic [FIELD_BITS-1:0] right_sample;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          wall_mode;
    logic [THR_BITS-1:0] left_threshold;
    logic [THR_BITS-1:0] right_threshold;
  } out_word_t;

  typedef struct packed {
    logic [REG_BITS-1:0] change_threshold;
    logic [REG_BITS-1:0] base_threshold;
    logic [REG_BITS-1:0] threshold_extra;
  } cfg_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SUM_BITS-1:0] change_sum;
  } lane_t;

endpackage

// ----- rtl/core/swmc_lane.sv -----
// One side lane of the side wall mode classifier: previous sample, change
// ring and running change sum, with a registered result for the merge stage.
// Depends on swmc_pkg.
module swmc_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [swmc_pkg::POS_BITS-1:0]   pos,
  input  logic [swmc_pkg::FIELD_BITS-1:0] sample,
  output swmc_pkg::lane_t                 result
);

  logic [swmc_pkg::SAMPLE_W-1:0] previous;
  logic [swmc_pkg::SAMPLE_W-1:0] ring [swmc_pkg::WINDOW];
  logic [swmc_pkg::SUM_BITS-1:0] change_sum;
  logic [swmc_pkg::SAMPLE_W-1:0] sample_cut;
  logic [swmc_pkg::SAMPLE_W-1:0] change;
  logic [swmc_pkg::SUM_BITS-1:0] change_sum_next;

  assign sample_cut = sample[swmc_pkg::SAMPLE_W-1:0];
  assign change     = (sample_cut >= previous) ? (sample_cut - previous)
                                               : (previous - sample_cut);
  // The oldest change leaves the window as the new one enters.
  assign change_sum_next = change_sum - swmc_pkg::SUM_BITS'(ring[pos])
                         + swmc_pkg::SUM_BITS'(change);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous   <= '0;
      change_sum <= '0;
      for (int k = 0; k < swmc_pkg::WINDOW; k++) begin
        ring[k] <= '0;
      end
    end else if (load) begin
      previous   <= sample_cut;
      change_sum <= change_sum_next;
      ring[pos]  <= change;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.sample     <= sample_cut;
      result.change_sum <= change_sum_next;
    end
  end

endmodule

// ----- rtl/core/swmc_merge.sv -----
// Merge stage of the side wall mode classifier: per-side threshold choice
// and the combined wall mode from both lanes' results.
// Depends on swmc_pkg.
module swmc_merge (
  input  swmc_pkg::cfg_t      cfg,
  input  swmc_pkg::lane_t     left_lane,
  input  swmc_pkg::lane_t     right_lane,
  output swmc_pkg::out_word_t word
);

  logic [swmc_pkg::CMP_BITS-1:0] limit;
  logic [swmc_pkg::THR_BITS-1:0] base_wide;
  logic [swmc_pkg::THR_BITS-1:0] raised;
  logic                          left_fast;
  logic                          right_fast;
  logic                          left_wall;
  logic                          right_wall;
  logic [1:0]                    mode;

  // A side's average change is above the threshold when its sum exceeds
  // change_threshold times the window length.
  assign limit      = swmc_pkg::CMP_BITS'(cfg.change_threshold)
                    * swmc_pkg::CMP_BITS'(swmc_pkg::WINDOW);
  assign left_fast  = swmc_pkg::CMP_BITS'(left_lane.change_sum) > limit;
  assign right_fast = swmc_pkg::CMP_BITS'(right_lane.change_sum) > limit;

  assign base_wide = swmc_pkg::THR_BITS'(cfg.base_threshold);
  assign raised    = base_wide + swmc_pkg::THR_BITS'(cfg.threshold_extra);

  assign word.left_threshold  = left_fast  ? raised : base_wide;
  assign word.right_threshold = right_fast ? raised : base_wide;

  assign left_wall  = swmc_pkg::THR_BITS'(left_lane.sample)  > word.left_threshold;
  assign right_wall = swmc_pkg::THR_BITS'(right_lane.sample) > word.right_threshold;

  always_comb begin
    case ({left_wall, right_wall})
      2'b11:   mode = swmc_pkg::MODE_BOTH;
      2'b10:   mode = swmc_pkg::MODE_LEFT;
      2'b01:   mode = swmc_pkg::MODE_RIGHT;
      default: mode = swmc_pkg::MODE_NONE;
    endcase
  end

  assign word.wall_mode = mode;

endmodule

// ----- rtl/core/side_wall_mode_classifier.sv -----
// Top level of the side wall mode classifier: configuration registers, ring
// position, two side lanes, the merge stage and the output register.
// Depends on swmc_pkg, swmc_lane and swmc_merge.
//
//   channel   direction  handshake                    word
//   sample    in         sample_valid / sample_stall  in_word_t (left, right)
//   result    out        result_valid / result_stall  out_word_t (mode, thresholds)
//   cfg       in         cfg_write                    cfg_index, cfg_data
//
// One word is accepted per cycle while sample_stall is low; each result passes
// through the lane stage, then the output register after the merge.
// The running sums make each word one subtract, add and compare.
// Synchronous reset clears the previous samples, change rings, sums, ring
// position, configuration registers and both stage valid flags.
// A stalled result holds; the lane stage still takes one more word behind it.
module side_wall_mode_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  swmc_pkg::in_word_t              sample_word,
  output logic                            result_valid,
  input  logic                            result_stall,
  output swmc_pkg::out_word_t             result_word,
  input  logic                            cfg_write,
  input  logic [swmc_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [swmc_pkg::REG_BITS-1:0]   cfg_data
);

  swmc_pkg::cfg_t                cfg;
  logic [swmc_pkg::POS_BITS-1:0] pos;
  logic [swmc_pkg::POS_BITS-1:0] pos_next;
  logic                          lane_valid;
  logic                          accept;
  logic                          out_load;
  swmc_pkg::lane_t               left_lane;
  swmc_pkg::lane_t               right_lane;
  swmc_pkg::out_word_t           merged;

  // Configuration writes; an index beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        swmc_pkg::REG_CHANGE_THRESHOLD: cfg.change_threshold <= cfg_data;
        swmc_pkg::REG_BASE_THRESHOLD:   cfg.base_threshold   <= cfg_data;
        swmc_pkg::REG_THRESHOLD_EXTRA:  cfg.threshold_extra  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The output register takes the lane word whenever it is empty or being drained; the lane
  // stage refills whenever it is empty or passing its word on.
  assign out_load     = lane_valid && (!result_valid || !result_stall);
  assign sample_stall = lane_valid && !out_load;
  assign accept       = sample_valid && !sample_stall;

  // Ring slot shared by both lanes, wrapping at the end of the window.
  assign pos_next = (pos == swmc_pkg::POS_LAST) ? '0 : pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      lane_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos <= pos_next;
      end
      if (accept) begin
        lane_valid <= 1'b1;
      end else if (out_load) begin
        lane_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  swmc_lane u_left (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .pos    (pos),
    .sample (sample_word.left_sample),
    .result (left_lane)
  );

  swmc_lane u_right (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .pos    (pos),
    .sample (sample_word.right_sample),
    .result (right_lane)
  );

  swmc_merge u_merge (
    .cfg        (cfg),
    .left_lane  (left_lane),
    .right_lane (right_lane),
    .word       (merged)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_word <= merged;
    end
  end

`ifndef SYNTHESIS
  // Input is held back only while the lane stage is occupied.
  assert property (@(posedge clk) disable iff (rst) sample_stall |-> lane_valid)
    else $error("sample stall raised with empty lane stage");

  // The ring position never leaves the window.
  assert property (@(posedge clk) disable iff (rst) pos <= swmc_pkg::POS_LAST)
    else $error("ring position outside window");

  // Each accepted word advances the ring position by one slot.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> pos == $past(pos_next))
    else $error("ring position did not advance");

  // A lane word with a free output register reaches the output next cycle.
  assert property (@(posedge clk) disable iff (rst) out_load |=> result_valid)
    else $error("lane word lost on the way to the output");

  // Running sums stay within the window's largest possible total.
  assert property (@(posedge clk) disable iff (rst)
    lane_valid |-> (left_lane.change_sum <= swmc_pkg::SUM_MAX &&
                    right_lane.change_sum <= swmc_pkg::SUM_MAX))
    else $error("change sum out of range");
`endif

endmodule
